// ===== rtl/ths_pkg.sv =====
// ths_pkg: shared types and constants of the task health supervisor
// request codes, health states, event and result payloads, configuration
// no dependencies
`default_nettype none

package ths_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAILURE_THRESHOLD = 2'd0,
    CFG_MAX_RETRIES       = 2'd1,
    CFG_RETRY_INTERVAL_MS = 2'd2
  } cfg_idx_t;

  // saturation limit of both counters
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  // reset values of the registers
  localparam logic [7:0]  RST_FAILURE_THRESHOLD = 8'd3;
  localparam logic [7:0]  RST_MAX_RETRIES       = 8'd3;
  localparam logic [31:0] RST_RETRY_INTERVAL_MS = 32'd1000;

  // request codes; the unused code acts as a query
  typedef enum logic [2:0] {
    REQ_INIT         = 3'd0,
    REQ_READ_OK      = 3'd1,
    REQ_READ_FAIL    = 3'd2,
    REQ_DEGRADE      = 3'd3,
    REQ_ATTEMPT      = 3'd4,
    REQ_RECOVER_FAIL = 3'd5,
    REQ_QUERY        = 3'd6
  } req_type_t;

  typedef enum logic [1:0] {
    HS_UNINIT   = 2'd0,
    HS_NORMAL   = 2'd1,
    HS_DEGRADED = 2'd2,
    HS_FAILED   = 2'd3
  } health_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] now_ms;
  } evt_t;

  typedef struct packed {
    logic [1:0] health_state;
    logic [7:0] fail_count;
    logic [7:0] fail_snapshot;
    logic [7:0] attempt_count;
    logic       should_degrade;
    logic       should_recover;
    logic       recovered_read;
    logic       available;
    logic       is_failed;
    logic       retries_exhausted;
  } res_t;

  typedef struct packed {
    logic [7:0]  failure_threshold;
    logic [7:0]  max_retries;
    logic [31:0] retry_interval_ms;
  } cfg_t;

  typedef struct packed {
    health_t     health;
    logic [7:0]  fails;
    logic        success;
    logic [7:0]  snapshot;
    logic [7:0]  attempts;
    logic [31:0] last_time;
  } sup_state_t;

endpackage

`default_nettype wire

// ===== rtl/ths_update.sv =====
// ths_update: one event applied to the supervisor state, plus the result
// computed from the updated state; purely combinational
// depends on ths_pkg
`default_nettype none

module ths_update import ths_pkg::*; (
  input  sup_state_t cur,
  input  cfg_t       cfg,
  input  evt_t       evt,
  output sup_state_t state_next,
  output res_t       res_next
);

  logic [31:0] elapsed;
  logic        thr_met;
  logic        interval_ok;

  always_comb begin
    state_next = cur;
    unique case (evt.req_type)
      REQ_INIT: begin
        state_next.health    = HS_NORMAL;
        state_next.snapshot  = '0;
        state_next.attempts  = '0;
        state_next.last_time = '0;
        state_next.fails     = '0;
        state_next.success   = 1'b1;
      end
      REQ_READ_OK: begin
        state_next.fails   = '0;
        state_next.success = 1'b1;
      end
      REQ_READ_FAIL: begin
        if (cur.fails != COUNT_MAX) begin
          state_next.fails = cur.fails + 8'd1;
        end
        state_next.success = 1'b0;
      end
      REQ_DEGRADE: begin
        if (cur.health != HS_FAILED) begin
          state_next.health   = HS_DEGRADED;
          state_next.snapshot = cur.fails;
        end
      end
      REQ_ATTEMPT: begin
        if (cur.health != HS_FAILED) begin
          state_next.health    = HS_DEGRADED;
          state_next.snapshot  = cur.fails;
          state_next.last_time = evt.now_ms;
          if (cur.attempts != COUNT_MAX) begin
            state_next.attempts = cur.attempts + 8'd1;
          end
        end
      end
      REQ_RECOVER_FAIL: begin
        if (cur.health != HS_FAILED) begin
          state_next.snapshot  = cur.fails;
          state_next.last_time = evt.now_ms;
          // out of retries: mark the task failed
          state_next.health = (cur.attempts >= cfg.max_retries) ? HS_FAILED : HS_DEGRADED;
        end
      end
      default: begin
        // query and the unused code leave the state alone
      end
    endcase
  end

  // wrapping interval since the last attempt or failed recovery
  assign elapsed     = evt.now_ms - state_next.last_time;
  assign thr_met     = state_next.fails >= cfg.failure_threshold;
  assign interval_ok = (state_next.attempts == '0) || (elapsed >= cfg.retry_interval_ms);

  always_comb begin
    res_next.health_state      = state_next.health;
    res_next.fail_count        = state_next.fails;
    res_next.fail_snapshot     = state_next.snapshot;
    res_next.attempt_count     = state_next.attempts;
    res_next.should_degrade    = (state_next.health == HS_NORMAL) && thr_met;
    res_next.should_recover    = (state_next.health == HS_DEGRADED) && thr_met &&
                                 !state_next.success && interval_ok;
    res_next.recovered_read    = (state_next.health == HS_DEGRADED) && state_next.success;
    res_next.available         = (state_next.health == HS_NORMAL) ||
                                 (state_next.health == HS_DEGRADED);
    res_next.is_failed         = state_next.health == HS_FAILED;
    res_next.retries_exhausted = state_next.attempts >= cfg.max_retries;
  end

endmodule

`default_nettype wire

// ===== rtl/task_health_supervisor.sv =====
// task_health_supervisor: top level of the fault supervisor for one task
// holds the event register, supervisor state, configuration and result register
// depends on ths_pkg and ths_update
`default_nettype none

// The supervisor takes one health event request per clock cycle while
// evt_stall is low and returns exactly one result per request, in order. A
// request in the event register is applied by the update logic to the
// health state and counters when the result register can advance, and the
// result is loaded with the state. The update is a handful of compares and
// saturating 8-bit increments plus one 32-bit wrapping subtract and compare
// for the retry interval, all between the event register and the result
// register, which sets the rate of one request per cycle when the output is
// not stalled. The event register refills while a finished result waits to
// be taken; evt_stall rises only when both the event register and the result
// register are full and res_stall is high. Configuration registers (failure
// threshold, max retries, retry interval) are written through
// cfg_we/cfg_index/cfg_data; the user must do so only while no request is in
// flight, which the block does not enforce. An index beyond the register
// list is ignored. After reset the task is uninitialized, all counts are zero,
// and the registers hold threshold 3, max retries 3, retry interval 1000 ms.

module task_health_supervisor import ths_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // event requests
  input  logic                  evt_valid,
  output logic                  evt_stall,
  input  evt_t                  evt,
  // results
  output logic                  res_valid,
  input  logic                  res_stall,
  output res_t                  res,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // event register
  logic       evt_q_valid;
  evt_t       evt_q;

  // supervisor state and registers
  sup_state_t state;
  sup_state_t state_next;
  cfg_t       cfg;
  res_t       res_next;

  // result register free or being taken this cycle
  logic       advance;

  assign advance   = !res_valid || !res_stall;
  // hold the request only when the event register cannot move on
  assign evt_stall = evt_q_valid && !advance;

  ths_update u_update (
    .cur        (state),
    .cfg        (cfg),
    .evt        (evt_q),
    .state_next (state_next),
    .res_next   (res_next)
  );

  // control, state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_q_valid           <= 1'b0;
      res_valid             <= 1'b0;
      state.health          <= HS_UNINIT;
      state.fails           <= '0;
      state.success         <= 1'b0;
      state.snapshot        <= '0;
      state.attempts        <= '0;
      state.last_time       <= '0;
      cfg.failure_threshold <= RST_FAILURE_THRESHOLD;
      cfg.max_retries       <= RST_MAX_RETRIES;
      cfg.retry_interval_ms <= RST_RETRY_INTERVAL_MS;
    end else begin
      if (!evt_stall) begin
        evt_q_valid <= evt_valid;
      end
      if (advance) begin
        res_valid <= evt_q_valid;
        // state commits together with the result it produced
        if (evt_q_valid) begin
          state <= state_next;
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FAILURE_THRESHOLD: cfg.failure_threshold <= cfg_data[7:0];
          CFG_MAX_RETRIES:       cfg.max_retries       <= cfg_data[7:0];
          CFG_RETRY_INTERVAL_MS: cfg.retry_interval_ms <= cfg_data[31:0];
          default: begin
            // no register at this index
          end
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (evt_valid && !evt_stall) begin
      evt_q <= evt;
    end
    if (advance && evt_q_valid) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ths_checker.sv =====
// ths_checker: port-level assertions on the task health supervisor
// bound to task_health_supervisor; depends on ths_pkg
`default_nettype none

module ths_checker import ths_pkg::*; (
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_stall,
  input res_t res
);

  // a stalled result stays offered and unchanged
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result dropped or changed");

  // nothing is offered right after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result offered after reset");

  // failed flag agrees with the reported state
  a_failed_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.is_failed == (res.health_state == HS_FAILED))
    else $error("is_failed disagrees with health_state");

  // degrade and recover advice come from different states
  a_advice_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.should_degrade && res.should_recover))
    else $error("degrade and recover advised together");

  // advice only for a task that is still available
  a_advice_avail: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.should_degrade || res.should_recover || res.recovered_read)
      |-> res.available && !res.is_failed)
    else $error("advice given for an unavailable task");

endmodule

bind task_health_supervisor ths_checker u_ths_checker (.*);

`default_nettype wire
